// ===== sv/ip6p_pkg.sv =====
// ip6p_pkg: types, constants and per-character parse functions for the ipv6 text parser
// no dependencies
package ip6p_pkg;

  localparam int GROUP_COUNT = 8;
  localparam logic [3:0] GROUP_CNT = 4'(GROUP_COUNT);

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_HEAD    = 3'd1;
  localparam logic [2:0] PH_TAIL    = 3'd2;
  localparam logic [2:0] PH_BRACKET = 3'd3;
  localparam logic [2:0] PH_STOP    = 3'd4;

  localparam logic [7:0] CH_OPEN  = 8'h5b;
  localparam logic [7:0] CH_CLOSE = 8'h5d;
  localparam logic [7:0] CH_COLON = 8'h3a;

  localparam logic [5:0] COUNT_MAX = 6'd63;

  typedef logic [7:0][15:0] group_arr_t;

  typedef struct packed {
    group_arr_t  head_groups;
    group_arr_t  tail_groups;
    logic [3:0]  head_count;
    logic [3:0]  tail_count;
    logic [15:0] accumulator;
    logic        token_open;
    logic [2:0]  phase;
    logic        colon_pending;
    logic [5:0]  char_count;
    logic        overflow_seen;
  } ip6p_state_t;

  localparam ip6p_state_t STATE_RESET = '{
    head_groups: '0, tail_groups: '0, head_count: '0, tail_count: '0,
    accumulator: '0, token_open: 1'b0, phase: PH_START, colon_pending: 1'b0,
    char_count: '0, overflow_seen: 1'b0
  };

  // bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] d;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b1, 4'(c - 8'h57)};
    end
    return d;
  endfunction

  function automatic logic [5:0] count_sat(logic [5:0] n);
    return (n < COUNT_MAX) ? n + 6'd1 : n;
  endfunction

  function automatic ip6p_state_t close_token(ip6p_state_t s);
    ip6p_state_t n;
    n = s;
    if (s.token_open) begin
      if (s.phase == PH_HEAD) begin
        if (s.head_count < GROUP_CNT) begin
          for (int i = 0; i < GROUP_COUNT; i++) begin
            if (s.head_count == 4'(i)) n.head_groups[i] = s.accumulator;
          end
          n.head_count = s.head_count + 4'd1;
        end else begin
          n.overflow_seen = 1'b1;
        end
      end else begin
        if (s.tail_count < GROUP_CNT) begin
          for (int i = 0; i < GROUP_COUNT; i++) begin
            if (s.tail_count == 4'(i)) n.tail_groups[i] = s.accumulator;
          end
          n.tail_count = s.tail_count + 4'd1;
        end else begin
          n.overflow_seen = 1'b1;
        end
      end
      n.token_open  = 1'b0;
      n.accumulator = '0;
    end
    return n;
  endfunction

  function automatic ip6p_state_t parse_char(ip6p_state_t s, logic [7:0] c);
    ip6p_state_t n;
    logic [4:0]  hd;
    logic        done;
    n    = s;
    done = 1'b0;
    hd   = hex_digit(c);
    if (n.phase == PH_STOP) begin
      done = 1'b1;
    end else if (n.phase == PH_BRACKET) begin
      if (c == CH_CLOSE) n.char_count = count_sat(n.char_count);
      n.phase = PH_STOP;
      done    = 1'b1;
    end
    if (!done && n.phase == PH_START) begin
      n.phase = PH_HEAD;
      if (c == CH_OPEN) begin
        n.char_count = count_sat(n.char_count);
        done         = 1'b1;
      end
    end
    if (!done && n.colon_pending) begin
      n.colon_pending = 1'b0;
      if (c == CH_COLON) begin
        n.char_count = count_sat(n.char_count);
        n.phase      = (n.phase == PH_HEAD) ? PH_TAIL : PH_BRACKET;
        done         = 1'b1;
      end
    end
    if (!done && hd[4]) begin
      n.accumulator = {n.accumulator[11:0], hd[3:0]};
      n.token_open  = 1'b1;
      n.char_count  = count_sat(n.char_count);
      done          = 1'b1;
    end
    if (!done) begin
      n = close_token(n);
      if (c == CH_COLON) begin
        n.char_count    = count_sat(n.char_count);
        n.colon_pending = 1'b1;
      end else begin
        if (c == CH_CLOSE) n.char_count = count_sat(n.char_count);
        n.phase = PH_STOP;
      end
    end
    return n;
  endfunction

endpackage

// ===== sv/ip6p_if.sv =====
// ip6p_in_if / ip6p_out_if: valid-ready channels for characters and parsed addresses
// no dependencies
interface ip6p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last;

  modport source (output valid, char_in, last, input ready);
  modport sink (input valid, char_in, last, output ready);
endinterface

interface ip6p_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] group0;
  logic [15:0] group1;
  logic [15:0] group2;
  logic [15:0] group3;
  logic [15:0] group4;
  logic [15:0] group5;
  logic [15:0] group6;
  logic [15:0] group7;
  logic [5:0]  consumed;
  logic        overflow;

  modport source (output valid, group0, group1, group2, group3, group4, group5, group6,
                  group7, consumed, overflow, input ready);
  modport sink (input valid, group0, group1, group2, group3, group4, group5, group6,
                group7, consumed, overflow, output ready);
endinterface

// ===== sv/ip6p_step.sv =====
// ip6p_step: one-character parse step and final group assembly
// depends on ip6p_pkg
module ip6p_step import ip6p_pkg::*; (
  input  ip6p_state_t st,
  input  logic [7:0]  char_in,
  output ip6p_state_t st_next,
  output group_arr_t  addr,
  output logic [5:0]  consumed,
  output logic        overflow
);

  ip6p_state_t st_fin;
  logic [3:0]  tail_idx;

  always_comb begin
    st_next = parse_char(st, char_in);
    st_fin  = st_next;
    if (st_next.phase == PH_HEAD || st_next.phase == PH_TAIL) st_fin = close_token(st_next);
  end

  // head groups from the front, tail groups right-aligned, tail wins on overlap
  always_comb begin
    addr     = '0;
    tail_idx = '0;
    for (int i = 0; i < GROUP_COUNT; i++) begin
      if (4'(i) < st_fin.head_count) addr[i] = st_fin.head_groups[i];
      if (4'(i) + st_fin.tail_count >= GROUP_CNT) begin
        tail_idx = 4'(i) + st_fin.tail_count - GROUP_CNT;
        addr[i]  = st_fin.tail_groups[tail_idx[2:0]];
      end
    end
  end

  assign consumed = st_fin.char_count;
  assign overflow = st_fin.overflow_seen;

endmodule

// ===== sv/ipv6_text_address_parser.sv =====
// ipv6_text_address_parser: ipv6 literal text to eight 16-bit groups
// depends on ip6p_pkg, ip6p_if, ip6p_step
//
//   channel  dir  payload                               item
//   chars    in   char_in[7:0], last                    one character
//   result   out  group0..group7, consumed, overflow    one parsed address
//
// one character accepted per cycle, back to back, through an input register, unless it stalls
// the parse state is updated when a character leaves the input register; a result is loaded
// into the output register at the same edge, so it is valid once its last character has left
// the input register
// a result held in the output register stalls only the character carrying last
// rst is synchronous and returns the parser to the start of a string
module ipv6_text_address_parser import ip6p_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  ip6p_in_if.sink         chars,
  ip6p_out_if.source      result
);

  logic        s_valid;
  logic [7:0]  s_char;
  logic        s_last;
  logic        s_adv;

  ip6p_state_t st;
  ip6p_state_t st_next;
  group_arr_t  addr;
  logic [5:0]  addr_consumed;
  logic        addr_overflow;

  logic        o_valid;
  group_arr_t  o_groups;
  logic [5:0]  o_consumed;
  logic        o_overflow;

  ip6p_step u_step (
    .st       (st),
    .char_in  (s_char),
    .st_next  (st_next),
    .addr     (addr),
    .consumed (addr_consumed),
    .overflow (addr_overflow)
  );

  assign s_adv       = s_valid && (!s_last || !o_valid || result.ready);
  assign chars.ready = !s_valid || s_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (chars.ready) begin
      s_valid <= chars.valid;
    end
    if (chars.ready && chars.valid) begin
      s_char <= chars.char_in;
      s_last <= chars.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (s_adv) begin
      st <= s_last ? STATE_RESET : st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s_adv && s_last) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
    if (s_adv && s_last) begin
      o_groups   <= addr;
      o_consumed <= addr_consumed;
      o_overflow <= addr_overflow;
    end
  end

  assign result.valid    = o_valid;
  assign result.group0   = o_groups[0];
  assign result.group1   = o_groups[1];
  assign result.group2   = o_groups[2];
  assign result.group3   = o_groups[3];
  assign result.group4   = o_groups[4];
  assign result.group5   = o_groups[5];
  assign result.group6   = o_groups[6];
  assign result.group7   = o_groups[7];
  assign result.consumed = o_consumed;
  assign result.overflow = o_overflow;

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    st.head_count <= GROUP_CNT && st.tail_count <= GROUP_CNT)
    else $error("group count beyond address width");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    o_valid && !result.ready |=> o_valid && $stable(o_groups) && $stable(o_consumed))
    else $error("stalled result lost or changed");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    s_adv && s_last |=> st.phase == PH_START && st.char_count == 6'd0 && !st.token_open)
    else $error("parser not back at start after a result");

  a_colon_phase: assert property (@(posedge clk) disable iff (rst)
    st.colon_pending |-> st.phase == PH_HEAD || st.phase == PH_TAIL)
    else $error("pending colon outside a group phase");

  a_stall_last_only: assert property (@(posedge clk) disable iff (rst)
    s_valid && !s_adv |-> s_last && o_valid)
    else $error("input register stalled without a held result");

endmodule
